### rtl/core/humidity_temp_frame_decoder_macros.svh
// Assertion macros for the humidity/temperature frame decoder.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef HUMIDITY_TEMP_FRAME_DECODER_MACROS_SVH
`define HUMIDITY_TEMP_FRAME_DECODER_MACROS_SVH

// Clocked check, off while reset is held.
`define HTF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Clocked check that also holds during reset.
`define HTF_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

### rtl/core/htf_pkg.sv
// Shared types and constants of the humidity/temperature frame decoder.
// No dependencies; used by htf_scale and the top level.
package htf_pkg;

  localparam logic [7:0] CrcInit      = 8'hFF;
  localparam logic [7:0] CrcPolyReset = 8'h31;

  localparam int TempScale = 175;
  localparam int HumScale  = 100;
  localparam int TempBias  = 45;

  localparam logic [1:0] CfgCrcPoly    = 2'd0;
  localparam logic [1:0] CfgTempOffset = 2'd1;
  localparam logic [1:0] CfgHumOffset  = 2'd2;

  typedef struct packed {
    logic [7:0] temp_high_byte;
    logic [7:0] temp_low_byte;
    logic [7:0] temp_check_byte;
    logic [7:0] hum_high_byte;
    logic [7:0] hum_low_byte;
    logic [7:0] hum_check_byte;
  } htf_in_t;

  typedef struct packed {
    logic signed [8:0] temperature;
    logic signed [7:0] humidity;
    logic              temp_crc_error;
    logic              hum_crc_error;
  } htf_out_t;

  typedef struct packed {
    logic        [7:0] crc_polynomial;
    logic signed [4:0] temperature_offset;
    logic signed [4:0] humidity_offset;
  } htf_cfg_t;

endpackage

### rtl/core/htf_crc8_byte.sv
// One byte of an MSB-first CRC-8 with a configurable generator.
// Depends on nothing outside this file.
module htf_crc8_byte (
  input  logic [7:0] crc_i,
  input  logic [7:0] byte_i,
  input  logic [7:0] poly_i,
  output logic [7:0] crc_o
);

  always_comb begin
    logic [7:0] crc;
    crc = crc_i ^ byte_i;
    for (int k = 0; k < 8; k++) begin
      if (crc[7]) begin
        crc = {crc[6:0], 1'b0} ^ poly_i;
      end else begin
        crc = {crc[6:0], 1'b0};
      end
    end
    crc_o = crc;
  end

endmodule

### rtl/core/htf_scale.sv
// Scaling of the pre-multiplied raw words to degrees and percent, with offsets.
// Depends on htf_pkg for the configuration type and the temperature bias.
module htf_scale (
  input  logic [23:0]        temp_prod_i,
  input  logic [22:0]        hum_prod_i,
  input  htf_pkg::htf_cfg_t  cfg_i,
  output logic signed [8:0]  temperature_o,
  output logic signed [7:0]  humidity_o
);

  logic [24:0] temp_sum;
  logic [7:0]  temp_quot;
  logic [23:0] temp_rem;
  logic        temp_inc;
  logic [9:0]  temp_val;
  logic [23:0] hum_sum;
  logic [6:0]  hum_quot;
  logic [7:0]  hum_val;

  // floor(x / 65535) = (x + 1 + (x >> 16)) >> 16 over the operand range
  assign temp_sum  = {1'b0, temp_prod_i} + 25'd1 + {17'd0, temp_prod_i[23:16]};
  assign temp_quot = temp_sum[23:16];
  assign temp_rem  = temp_prod_i - ({temp_quot, 16'h0000} - {16'h0000, temp_quot});
  assign temp_inc  = (temp_quot < 8'(htf_pkg::TempBias)) && (temp_rem != 24'd0);
  assign temp_val  = {2'b00, temp_quot} - 10'(htf_pkg::TempBias) + {9'd0, temp_inc}
                   - {{5{cfg_i.temperature_offset[4]}}, cfg_i.temperature_offset};

  assign hum_sum  = {1'b0, hum_prod_i} + 24'd1 + {17'd0, hum_prod_i[22:16]};
  assign hum_quot = hum_sum[22:16];
  assign hum_val  = {1'b0, hum_quot}
                  + {{3{cfg_i.humidity_offset[4]}}, cfg_i.humidity_offset};

  assign temperature_o = temp_val[8:0];
  assign humidity_o    = hum_val;

endmodule

### rtl/core/humidity_temp_frame_decoder.sv
// Top level of the humidity/temperature frame decoder: config registers,
// input stage, CRC check, scaling and result register. Uses htf_pkg,
// htf_crc8_byte, htf_scale and the assertion macros header.
//
//  channel  direction  handshake                 payload
//  in       input      in_valid_i / in_stall_o   htf_in_t frame
//  out      output     out_valid_o / out_stall_i htf_out_t result
//  cfg      input      cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// One frame per cycle while no stalled result holds the input stage; a taken
// frame passes the input stage (high-byte CRC, constant multiplies) and the
// result register (low-byte CRC, divide by 65535, offsets) to give its result.
// Reset clears the stored temperature and humidity to zero and loads the
// default polynomial; config writes are taken in every cycle.
// A stalled result holds both stages; input stalls only when both are full.
`include "humidity_temp_frame_decoder_macros.svh"

module humidity_temp_frame_decoder (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  htf_pkg::htf_in_t   in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output htf_pkg::htf_out_t  out_data_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [7:0]         cfg_data_i
);

  htf_pkg::htf_cfg_t cfg_q, cfg_d;

  logic        s1_valid_q, s1_valid_d;
  logic [7:0]  temp_crc_q, hum_crc_q;
  logic [7:0]  temp_low_q, hum_low_q;
  logic [7:0]  temp_chk_q, hum_chk_q;
  logic [23:0] temp_prod_q;
  logic [22:0] hum_prod_q;

  logic [7:0]  temp_crc_hi, hum_crc_hi;
  logic [7:0]  temp_crc_fin, hum_crc_fin;
  logic [23:0] temp_prod_d;
  logic [22:0] hum_prod_d;
  logic        temp_err, hum_err;
  logic signed [8:0] temp_new;
  logic signed [7:0] hum_new;

  logic              out_valid_q, out_valid_d;
  htf_pkg::htf_out_t out_q, out_d;

  logic in_accept, out_free, advance;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        htf_pkg::CfgCrcPoly:    cfg_d.crc_polynomial     = cfg_data_i;
        htf_pkg::CfgTempOffset: cfg_d.temperature_offset = cfg_data_i[4:0];
        htf_pkg::CfgHumOffset:  cfg_d.humidity_offset    = cfg_data_i[4:0];
        default:                cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.crc_polynomial     <= htf_pkg::CrcPolyReset;
      cfg_q.temperature_offset <= '0;
      cfg_q.humidity_offset    <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // input stage: high-byte CRC and constant multiplies
  htf_crc8_byte u_temp_crc_hi (
    .crc_i  (htf_pkg::CrcInit),
    .byte_i (in_data_i.temp_high_byte),
    .poly_i (cfg_q.crc_polynomial),
    .crc_o  (temp_crc_hi)
  );

  htf_crc8_byte u_hum_crc_hi (
    .crc_i  (htf_pkg::CrcInit),
    .byte_i (in_data_i.hum_high_byte),
    .poly_i (cfg_q.crc_polynomial),
    .crc_o  (hum_crc_hi)
  );

  assign temp_prod_d = {8'h00, in_data_i.temp_high_byte, in_data_i.temp_low_byte}
                     * 24'(htf_pkg::TempScale);
  assign hum_prod_d  = {7'h00, in_data_i.hum_high_byte, in_data_i.hum_low_byte}
                     * 23'(htf_pkg::HumScale);

  assign out_free   = !out_valid_q || !out_stall_i;
  assign advance    = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign in_accept  = in_valid_i && !in_stall_o;

  assign s1_valid_d = in_accept ? 1'b1 : (advance ? 1'b0 : s1_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      temp_crc_q  <= temp_crc_hi;
      hum_crc_q   <= hum_crc_hi;
      temp_low_q  <= in_data_i.temp_low_byte;
      hum_low_q   <= in_data_i.hum_low_byte;
      temp_chk_q  <= in_data_i.temp_check_byte;
      hum_chk_q   <= in_data_i.hum_check_byte;
      temp_prod_q <= temp_prod_d;
      hum_prod_q  <= hum_prod_d;
    end
  end

  // second stage: finish CRC, scale, update stored values
  htf_crc8_byte u_temp_crc_lo (
    .crc_i  (temp_crc_q),
    .byte_i (temp_low_q),
    .poly_i (cfg_q.crc_polynomial),
    .crc_o  (temp_crc_fin)
  );

  htf_crc8_byte u_hum_crc_lo (
    .crc_i  (hum_crc_q),
    .byte_i (hum_low_q),
    .poly_i (cfg_q.crc_polynomial),
    .crc_o  (hum_crc_fin)
  );

  assign temp_err = temp_crc_fin != temp_chk_q;
  assign hum_err  = hum_crc_fin != hum_chk_q;

  htf_scale u_scale (
    .temp_prod_i   (temp_prod_q),
    .hum_prod_i    (hum_prod_q),
    .cfg_i         (cfg_q),
    .temperature_o (temp_new),
    .humidity_o    (hum_new)
  );

  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d          = 1'b1;
      out_d.temp_crc_error = temp_err;
      out_d.hum_crc_error  = hum_err;
      if (!temp_err) begin
        out_d.temperature = temp_new;
      end
      if (!hum_err) begin
        out_d.humidity = hum_new;
      end
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // stored values live in the result register and reset to zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `HTF_ASSERT(a_stage_holds, in_stall_o |=> s1_valid_q, "stalled frame lost from input stage")
  `HTF_ASSERT(a_advance_valid, advance |=> out_valid_q, "advanced frame gave no result")
  `HTF_ASSERT(a_temp_kept, (advance && temp_err) |=> $stable(out_q.temperature),
              "temperature changed on CRC failure")
  `HTF_ASSERT(a_hum_kept, (advance && hum_err) |=> $stable(out_q.humidity),
              "humidity changed on CRC failure")
  `HTF_ASSERT_ALWAYS(a_reset_idle, !rst_ni |=> (!out_valid_q || !rst_ni),
                     "result valid straight out of reset")

endmodule
